FILE: sv/lru_pr_pkg.sv
// Shared constants and types for the LRU page replacement block.
`default_nettype none

package lru_pr_pkg;

    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    localparam int CFG_W   = 4;
    localparam int STAMP_W = 32;
    localparam int FAULT_W = 32;
    localparam int SLOT_W  = 3;

    localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
    localparam logic [STAMP_W-1:0] STAMP_MAX = '1;
    localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

    localparam int RES_BITS = 1 + SLOT_W + 1 + FAULT_W;
    localparam int OUT_W    = ((RES_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic               hit;
        logic [SLOT_W-1:0]  slot;
        logic               filled;
        logic [FAULT_W-1:0] fault;
    } t_result;

endpackage

`default_nettype wire

FILE: sv/lru_pr_frame_ram.sv
// Frame memory: resident page and last-use stamp per frame, one write and one read port.
`default_nettype none

module lru_pr_frame_ram #(
    parameter int DEPTH = lru_pr_pkg::FRAMES_DEF,
    parameter int WIDTH = lru_pr_pkg::PAGE_BITS_DEF + lru_pr_pkg::STAMP_W,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

FILE: sv/lru_pr_engine.sv
// Scan sequencer: reads every active frame, picks the slot, writes back and counts.
`default_nettype none

module lru_pr_engine #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
    parameter int IDX_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1,
    parameter int CNT_W     = $clog2(FRAMES + 1),
    parameter int WORD_W    = PAGE_BITS + lru_pr_pkg::STAMP_W
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_start,
    input  wire logic [PAGE_BITS-1:0]  i_page,
    input  wire logic [CNT_W-1:0]      i_active,
    input  wire logic                  i_out_free,
    output logic                       o_idle,
    output logic                       o_res_valid,
    output lru_pr_pkg::t_result        o_res,
    output logic                       o_re,
    output logic [IDX_W-1:0]           o_raddr,
    input  wire logic [WORD_W-1:0]     i_rdata,
    output logic                       o_we,
    output logic [IDX_W-1:0]           o_waddr,
    output logic [WORD_W-1:0]          o_wdata
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_UPDATE = 2'd2;

    localparam int STAMP_W = lru_pr_pkg::STAMP_W;

    logic [1:0]               r_state, n_state;
    logic [PAGE_BITS-1:0]     r_page;
    logic [CNT_W-1:0]         r_n;
    logic [CNT_W-1:0]         r_addr;
    logic                     r_eval;
    logic [IDX_W-1:0]         r_eval_idx;
    logic                     r_found;
    logic [IDX_W-1:0]         r_hit_idx;
    logic                     r_empty;
    logic [IDX_W-1:0]         r_empty_idx;
    logic [STAMP_W-1:0]       r_best;
    logic [IDX_W-1:0]         r_best_idx;
    logic [FRAMES-1:0]        r_valid;
    logic [STAMP_W-1:0]       r_use;
    logic [lru_pr_pkg::FAULT_W-1:0] r_fault;

    logic [PAGE_BITS-1:0]     rd_page;
    logic [STAMP_W-1:0]       rd_stamp;
    logic                     rd_valid;
    logic                     eval_last;
    logic [IDX_W-1:0]         slot;
    logic [STAMP_W-1:0]       n_use;
    logic [lru_pr_pkg::FAULT_W-1:0] n_fault;
    logic                     commit;

    assign rd_page   = i_rdata[WORD_W-1:STAMP_W];
    assign rd_stamp  = i_rdata[STAMP_W-1:0];
    assign rd_valid  = r_valid[r_eval_idx];
    assign eval_last = r_eval && (CNT_W'(r_eval_idx) == (r_n - CNT_W'(1)));

    assign o_idle  = (r_state == ST_IDLE);
    assign o_re    = (r_state == ST_SCAN) && (r_addr < r_n);
    assign o_raddr = r_addr[IDX_W-1:0];

    always_comb begin
        if (r_found) begin
            slot = r_hit_idx;
        end else if (r_empty) begin
            slot = r_empty_idx;
        end else begin
            slot = r_best_idx;
        end
    end

    assign n_use   = (r_use == lru_pr_pkg::STAMP_MAX) ? r_use : r_use + STAMP_W'(1);
    assign n_fault = (r_found || r_fault == lru_pr_pkg::FAULT_MAX) ? r_fault
                   : r_fault + lru_pr_pkg::FAULT_W'(1);
    assign commit  = (r_state == ST_UPDATE) && i_out_free;

    assign o_we    = commit;
    assign o_waddr = slot;
    assign o_wdata = {r_page, n_use};

    assign o_res_valid  = commit;
    assign o_res.hit    = r_found;
    assign o_res.slot   = lru_pr_pkg::SLOT_W'(slot);
    assign o_res.filled = !r_found && r_empty;
    assign o_res.fault  = n_fault;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (eval_last) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_eval  <= 1'b0;
            r_valid <= '0;
            r_use   <= '0;
            r_fault <= '0;
        end else begin
            r_state <= n_state;
            r_eval  <= o_re;
            if (commit) begin
                r_valid[slot] <= 1'b1;
                r_use         <= n_use;
                r_fault       <= n_fault;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_idle && i_start) begin
            r_page  <= i_page;
            r_n     <= i_active;
            r_addr  <= '0;
            r_found <= 1'b0;
            r_empty <= 1'b0;
        end else begin
            if (o_re) begin
                r_addr <= r_addr + CNT_W'(1);
            end
            if (r_eval) begin
                if (rd_valid && rd_page == r_page && !r_found) begin
                    r_found   <= 1'b1;
                    r_hit_idx <= r_eval_idx;
                end
                if (!rd_valid && !r_empty) begin
                    r_empty     <= 1'b1;
                    r_empty_idx <= r_eval_idx;
                end
                if (r_eval_idx == '0 || rd_stamp < r_best) begin
                    r_best     <= rd_stamp;
                    r_best_idx <= r_eval_idx;
                end
            end
        end
        r_eval_idx <= o_raddr;
    end

endmodule

`default_nettype wire

FILE: sv/lru_page_replacement.sv
// Top level: configuration register, frame memory, scan engine and output register.
// A reference is taken only while the scan engine is idle; the scan and update states then run
// and the result enters the output register once it is free. The single read port of the frame
// memory is swept once per reference over the n active frames (1..FRAMES), one frame per cycle.
// Reset: synchronous, active low; frames empty, use and fault counters zero,
// frames_in_use = 8, output register empty. No memory clearing pass.
`default_nettype none

module lru_page_replacement #(
    parameter int FRAMES    = lru_pr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lru_pr_pkg::PAGE_BITS_DEF,
    parameter int IN_W      = ((PAGE_BITS + 7) / 8) * 8
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_s_tvalid,
    output logic                               o_s_tready,
    input  wire logic [IN_W-1:0]               i_s_tdata,   // page_id
    output logic                               o_m_tvalid,
    input  wire logic                          i_m_tready,
    output logic [lru_pr_pkg::OUT_W-1:0]       o_m_tdata,   // hit, frame_slot, filled_empty, fault_total
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lru_pr_pkg::CFG_W-1:0]  i_cfg_data   // frames_in_use
);

    localparam int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W  = $clog2(FRAMES + 1);
    localparam int WORD_W = PAGE_BITS + lru_pr_pkg::STAMP_W;
    localparam int PAD_W  = lru_pr_pkg::OUT_W - lru_pr_pkg::RES_BITS;

    logic [lru_pr_pkg::CFG_W-1:0] r_cfg;
    logic [CNT_W-1:0]             active;
    logic                         r_m_valid, n_m_valid;
    logic [lru_pr_pkg::OUT_W-1:0] r_m_tdata;
    logic                         eng_idle;
    logic                         out_free;
    logic                         res_valid;
    lru_pr_pkg::t_result          res;
    logic                         ram_re, ram_we;
    logic [IDX_W-1:0]             ram_raddr, ram_waddr;
    logic [WORD_W-1:0]            ram_rdata, ram_wdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lru_pr_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_cfg == '0) begin
            active = CNT_W'(1);
        end else if (32'(r_cfg) > 32'(FRAMES)) begin
            active = CNT_W'(FRAMES);
        end else begin
            active = CNT_W'(r_cfg);
        end
    end

    assign o_s_tready = eng_idle;
    assign out_free   = !r_m_valid || i_m_tready;

    lru_pr_frame_ram #(
        .DEPTH (FRAMES),
        .WIDTH (WORD_W),
        .AW    (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lru_pr_engine #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS),
        .IDX_W     (IDX_W),
        .CNT_W     (CNT_W),
        .WORD_W    (WORD_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_s_tvalid),
        .i_page      (i_s_tdata[PAGE_BITS-1:0]),
        .i_active    (active),
        .i_out_free  (out_free),
        .o_idle      (eng_idle),
        .o_res_valid (res_valid),
        .o_res       (res),
        .o_re        (ram_re),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata),
        .o_we        (ram_we),
        .o_waddr     (ram_waddr),
        .o_wdata     (ram_wdata)
    );

    always_comb begin
        if (res_valid) begin
            n_m_valid = 1'b1;
        end else if (i_m_tready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_m_tdata <= {{PAD_W{1'b0}}, res.fault, res.filled, res.slot, res.hit};
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;

endmodule

`default_nettype wire

FILE: sv/lru_pr_checker.sv
// Port-level assertions for the LRU page replacement block, bound to the top level.
`default_nettype none

module lru_pr_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_s_tvalid,
    input wire logic                          o_s_tready,
    input wire logic                          o_m_tvalid,
    input wire logic                          i_m_tready,
    input wire logic [lru_pr_pkg::OUT_W-1:0]  o_m_tdata
);

    localparam int FLT_LO = 1 + lru_pr_pkg::SLOT_W + 1;
    localparam int FLT_HI = FLT_LO + lru_pr_pkg::FAULT_W - 1;
    localparam int FIL_B  = 1 + lru_pr_pkg::SLOT_W;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed or dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hit_not_filled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[0] && o_m_tdata[FIL_B]))
        else $error("hit reported together with empty fill");

    a_fault_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tdata[0] |-> o_m_tdata[FLT_HI:FLT_LO] != '0)
        else $error("fault reported with zero fault total");

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("input taken again while scan in progress");

endmodule

bind lru_page_replacement lru_pr_checker u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire
